[sv/hotp_totp_code_generator_unit_defines.svh]
// assertion macros for the one-time code generator
`ifndef HOTP_TOTP_CODE_GENERATOR_UNIT_DEFINES_SVH
`define HOTP_TOTP_CODE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define HTCG_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("htcg same-cycle check failed");

// next-cycle implication
`define HTCG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("htcg next-cycle check failed");

`endif

[sv/htcg_pkg.sv]
// shared types, constants and functions of the one-time code generator
package htcg_pkg;

    localparam int KEY_BYTES = 20;
    localparam int KEY_MAX   = (KEY_BYTES < 20) ? KEY_BYTES : 20;

    typedef enum logic [2:0] {
        CFG_KEY_FIRST  = 3'd0,
        CFG_KEY_MIDDLE = 3'd1,
        CFG_KEY_LAST   = 3'd2,
        CFG_KEY_LENGTH = 3'd3,
        CFG_DIGITS     = 3'd4,
        CFG_STEP       = 3'd5
    } cfg_idx_t;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    typedef struct packed {
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       c;
        logic [31:0]       d;
        logic [31:0]       e;
        logic [15:0][31:0] w;
        logic [4:0][31:0]  h;
    } sha_st_t;

    function automatic sha_st_t sha1_round(sha_st_t s, int unsigned r);
        logic [31:0] f;
        logic [31:0] k;
        logic [31:0] t;
        logic [31:0] wn;
        sha_st_t     n;
        if (r < 20) begin
            f = (s.b & s.c) | (~s.b & s.d);
            k = 32'h5A827999;
        end else if (r < 40) begin
            f = s.b ^ s.c ^ s.d;
            k = 32'h6ED9EBA1;
        end else if (r < 60) begin
            f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
            k = 32'h8F1BBCDC;
        end else begin
            f = s.b ^ s.c ^ s.d;
            k = 32'hCA62C1D6;
        end
        t  = {s.a[26:0], s.a[31:27]} + f + s.e + k + s.w[0];
        wn = s.w[13] ^ s.w[8] ^ s.w[2] ^ s.w[0];
        n   = s;
        n.e = s.d;
        n.d = s.c;
        n.c = {s.b[1:0], s.b[31:2]};
        n.b = s.a;
        n.a = t;
        for (int j = 0; j < 15; j++) begin
            n.w[j] = s.w[j+1];
        end
        n.w[15] = {wn[30:0], wn[31]};
        return n;
    endfunction

    function automatic logic [33:0] pow10(logic [3:0] digits);
        logic [33:0] m;
        unique case (digits)
            4'd0:    m = 34'd1;
            4'd1:    m = 34'd10;
            4'd2:    m = 34'd100;
            4'd3:    m = 34'd1000;
            4'd4:    m = 34'd10000;
            4'd5:    m = 34'd100000;
            4'd6:    m = 34'd1000000;
            4'd7:    m = 34'd10000000;
            4'd8:    m = 34'd100000000;
            4'd9:    m = 34'd1000000000;
            default: m = 34'd10000000000;
        endcase
        return m;
    endfunction

endpackage

[sv/htcg_div.sv]
// pipelined restoring divider, one quotient bit per stage
module htcg_div import htcg_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       dividend,
    input  logic [31:0]       divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [31:0]       quotient,
    output logic [SIDE_W-1:0] side_out
);

    localparam int Bits = 64;

    logic [Bits:0]       v_reg;
    logic [63:0]         dvd_reg  [0:Bits];
    logic [31:0]         rem_reg  [0:Bits];
    logic [31:0]         q_reg    [0:Bits];
    logic [SIDE_W-1:0]   side_reg [0:Bits];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[Bits-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg[0]  <= dividend;
            rem_reg[0]  <= '0;
            q_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar s = 0; s < Bits; s++) begin : g_stage
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;
        always_comb begin
            trial = {rem_reg[s], dvd_reg[s][63]};
            diff  = trial - {1'b0, divisor};
            ge    = (trial >= {1'b0, divisor});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dvd_reg[s+1]  <= {dvd_reg[s][62:0], 1'b0};
                rem_reg[s+1]  <= ge ? diff[31:0] : trial[31:0];
                q_reg[s+1]    <= {q_reg[s][30:0], ge};
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = v_reg[Bits];
    assign quotient  = q_reg[Bits];
    assign side_out  = side_reg[Bits];

endmodule

[sv/htcg_sha1_comp.sv]
// one sha-1 block compression, one round per pipeline stage
module htcg_sha1_comp import htcg_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [159:0]      h_in,
    input  logic [511:0]      blk_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [159:0]      digest,
    output logic [SIDE_W-1:0] side_out
);

    localparam int Rounds = 80;

    logic [Rounds+1:0] v_reg;
    sha_st_t           st_reg   [0:Rounds];
    logic [SIDE_W-1:0] side_reg [0:Rounds+1];
    logic [159:0]      dig_reg;
    sha_st_t           st_load;

    always_comb begin
        st_load.a = h_in[159:128];
        st_load.b = h_in[127:96];
        st_load.c = h_in[95:64];
        st_load.d = h_in[63:32];
        st_load.e = h_in[31:0];
        for (int i = 0; i < 16; i++) begin
            st_load.w[i] = blk_in[511-32*i -: 32];
        end
        for (int i = 0; i < 5; i++) begin
            st_load.h[i] = h_in[159-32*i -: 32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[Rounds:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]   <= st_load;
            side_reg[0] <= side_in;
        end
    end

    for (genvar r = 0; r < Rounds; r++) begin : g_round
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[r+1]   <= sha1_round(st_reg[r], r);
                side_reg[r+1] <= side_reg[r];
            end
        end
    end

    // feed-forward add of the chaining value
    always_ff @(posedge aclk) begin
        if (en) begin
            dig_reg <= {st_reg[Rounds].h[0] + st_reg[Rounds].a,
                        st_reg[Rounds].h[1] + st_reg[Rounds].b,
                        st_reg[Rounds].h[2] + st_reg[Rounds].c,
                        st_reg[Rounds].h[3] + st_reg[Rounds].d,
                        st_reg[Rounds].h[4] + st_reg[Rounds].e};
            side_reg[Rounds+1] <= side_reg[Rounds];
        end
    end

    assign out_valid = v_reg[Rounds+1];
    assign digest    = dig_reg;
    assign side_out  = side_reg[Rounds+1];

endmodule

[sv/hotp_totp_code_generator_unit.sv]
// top level of the hotp/totp one-time code generator
//
// Input beats on s_*: s_tuser is the mode (0 = time in seconds, 1 = raw
// counter) and s_tdata the 64-bit value. Each beat gives one result beat
// on m_*: m_tdata[30:0] is the code, the truncated hmac-sha1 value modulo
// ten to the configured digit count (at most ten). Configuration goes
// through cfg_we / cfg_index / cfg_wdata, one register per write. The user
// must change it only while no beat is in flight; the block has no check.
// An accepted beat reaches m_tvalid through 344 register stages: 65 in the
// time-step divider (an input stage, then one quotient bit each), three
// sha-1 compressions of 82 each (load, one round per stage, feed-forward;
// key-pad blocks hashed side by side), one truncation stage, 31 modulo
// stages and the output register. One beat per cycle while s_tready is high.
// Reset clears all valid bits and loads the default key length, digit
// count and time step; the key resets to zero.
// When the receiver stalls, one more result lands in a skid register and
// then the whole pipeline holds with s_tready low, losing nothing.
`include "hotp_totp_code_generator_unit_defines.svh"

module hotp_totp_code_generator_unit import htcg_pkg::*; #(
    parameter int KEY_LIMIT = KEY_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // code[30:0], zero[31]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int ModStages = 31;
    localparam int KeyMax    = (KEY_LIMIT < 20) ? KEY_LIMIT : 20;

    // configuration
    logic [63:0] key_first_reg;
    logic [63:0] key_middle_reg;
    logic [31:0] key_last_reg;
    logic [4:0]  key_len_reg;
    logic [3:0]  digits_reg;
    logic [31:0] step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_first_reg  <= '0;
            key_middle_reg <= '0;
            key_last_reg   <= '0;
            key_len_reg    <= 5'd20;
            digits_reg     <= 4'd6;
            step_reg       <= 32'd30;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_FIRST:  key_first_reg  <= cfg_wdata;
                CFG_KEY_MIDDLE: key_middle_reg <= cfg_wdata;
                CFG_KEY_LAST:   key_last_reg   <= cfg_wdata[31:0];
                CFG_KEY_LENGTH: key_len_reg    <= cfg_wdata[4:0];
                CFG_DIGITS:     digits_reg     <= cfg_wdata[3:0];
                CFG_STEP:       step_reg       <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // key pads
    logic [4:0]   klen_eff;
    logic [159:0] key_all;
    logic [159:0] key_mask;
    logic [511:0] ipad_blk;
    logic [511:0] opad_blk;
    logic [31:0]  step_eff;

    always_comb begin
        klen_eff = (key_len_reg > 5'(KeyMax)) ? 5'(KeyMax) : key_len_reg;
        key_all  = {key_first_reg, key_middle_reg, key_last_reg};
        for (int i = 0; i < 20; i++) begin
            key_mask[159-8*i -: 8] = (5'(i) < klen_eff) ? 8'hFF : 8'h00;
        end
        ipad_blk = {key_all & key_mask, 352'b0} ^ {64{8'h36}};
        opad_blk = {key_all & key_mask, 352'b0} ^ {64{8'h5C}};
        step_eff = (step_reg == 32'd0) ? 32'd1 : step_reg;
    end

    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // time step division
    logic        div_valid;
    logic [31:0] div_q;
    logic [64:0] div_side;
    logic [63:0] ctr;

    htcg_div #(.SIDE_W(65)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .dividend  (s_tdata),
        .divisor   (step_eff),
        .side_in   ({s_tuser[0], s_tdata}),
        .out_valid (div_valid),
        .quotient  (div_q),
        .side_out  (div_side)
    );

    assign ctr = div_side[64] ? div_side[63:0] : {32'b0, div_q};

    // key-pad blocks
    logic         a1_valid;
    logic [159:0] a1_dig;
    logic [63:0]  a1_ctr;
    logic [159:0] a2_dig;

    htcg_sha1_comp #(.SIDE_W(64)) u_ipad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .h_in      (SHA1_IV),
        .blk_in    (ipad_blk),
        .side_in   (ctr),
        .out_valid (a1_valid),
        .digest    (a1_dig),
        .side_out  (a1_ctr)
    );

    htcg_sha1_comp #(.SIDE_W(1)) u_opad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .h_in      (SHA1_IV),
        .blk_in    (opad_blk),
        .side_in   (1'b0),
        .out_valid (),
        .digest    (a2_dig),
        .side_out  ()
    );

    // inner hash, counter block
    logic         b_valid;
    logic [159:0] b_dig;
    logic [159:0] b_opad;

    htcg_sha1_comp #(.SIDE_W(160)) u_inner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a1_valid),
        .h_in      (a1_dig),
        .blk_in    ({a1_ctr, 8'h80, 376'b0, 64'd576}),
        .side_in   (a2_dig),
        .out_valid (b_valid),
        .digest    (b_dig),
        .side_out  (b_opad)
    );

    // outer hash, inner digest block
    logic         c_valid;
    logic [159:0] c_dig;

    htcg_sha1_comp #(.SIDE_W(1)) u_outer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid),
        .h_in      (b_opad),
        .blk_in    ({b_dig, 8'h80, 280'b0, 64'd672}),
        .side_in   (1'b0),
        .out_valid (c_valid),
        .digest    (c_dig),
        .side_out  ()
    );

    // dynamic truncation, then modulo by shifted compare and subtract
    logic [159:0]       trunc_sh;
    logic [33:0]        modulus;
    logic [ModStages:0] mv_reg;
    logic [30:0]        x_reg [0:ModStages];

    assign trunc_sh = c_dig << {c_dig[3:0], 3'b000};
    assign modulus  = pow10(digits_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= '0;
        end else if (en) begin
            mv_reg <= {mv_reg[ModStages-1:0], c_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= trunc_sh[158:128];
        end
    end

    for (genvar j = 0; j < ModStages; j++) begin : g_mod
        logic [63:0] cand;
        logic        ge;
        always_comb begin
            cand = {30'b0, modulus} << (ModStages - 1 - j);
            ge   = ({33'b0, x_reg[j]} >= cand);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[j+1] <= ge ? (x_reg[j] - cand[30:0]) : x_reg[j];
            end
        end
    end

    // output register and skid
    logic        pipe_valid;
    logic        out_valid_reg;
    logic [30:0] out_reg;
    logic [30:0] skid_reg;

    assign pipe_valid = mv_reg[ModStages];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= pipe_valid;
        end else if (pipe_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_reg <= x_reg[ModStages];
        end else begin
            skid_reg <= x_reg[ModStages];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    `HTCG_ASSERT_SAME(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `HTCG_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_tready, !skid_valid_reg && out_valid_reg)
    `HTCG_ASSERT_NEXT(a_stall_catches, aclk, aresetn, out_valid_reg && !m_tready && !skid_valid_reg && pipe_valid, skid_valid_reg)

endmodule

[tb/sv/tb_hotp_totp_code_generator_unit.sv]
// testbench of the hotp/totp code generator: hmac-sha1 predictor, random beats, scoreboard
module tb_hotp_totp_code_generator_unit;
    import htcg_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // value[63:0]
    logic [0:0]  s_tuser;   // mode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // code[30:0], zero[31]
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_wdata;

    hotp_totp_code_generator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor copy of the registers
    logic [63:0] key_hi;
    logic [63:0] key_mid;
    logic [31:0] key_lo;
    logic [4:0]  key_len;
    logic [3:0]  digits;
    logic [31:0] step_sec;

    logic [30:0] code_q[$];
    int          n_err;
    int          burst_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] compress(logic [159:0] hv, logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        {a, b, c, d, e} = hv;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
    endfunction

    function automatic logic [30:0] otp_code(logic mode, logic [63:0] val);
        logic [159:0] kfull, inner, mac;
        logic [511:0] kblk, blk;
        logic [63:0]  cnt, mod, stp;
        logic [31:0]  bin;
        logic [3:0]   off;
        int           len;
        len = (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
        kfull = {key_hi, key_mid, key_lo};
        kblk = '0;
        for (int i = 0; i < len; i++) kblk[511 - 8*i -: 8] = kfull[159 - 8*i -: 8];
        if (mode) begin
            cnt = val;
        end else begin
            stp = (step_sec == 0) ? 64'd1 : {32'd0, step_sec};
            cnt = {32'd0, 32'(val / stp)};
        end
        // inner hash: ipad block, then counter with padding (72 bytes total)
        inner = compress(SHA1_IV, kblk ^ {64{8'h36}});
        blk = {cnt, 8'h80, 376'd0, 64'd576};
        inner = compress(inner, blk);
        mac = compress(SHA1_IV, kblk ^ {64{8'h5C}});
        blk = {inner, 8'h80, 280'd0, 64'd672};
        mac = compress(mac, blk);
        off = mac[3:0];
        bin = mac[159 - 8*off -: 32] & 32'h7FFFFFFF;
        mod = 1;
        for (int i = 0; i < digits && i < 10; i++) mod = mod * 10;
        return 31'(bin % mod);
    endfunction

    task automatic report_mismatch(string what, logic [30:0] got, logic [30:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_err++;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (code_q.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[30:0], 31'd0);
            end else begin
                logic [30:0] want;
                want = code_q.pop_front();
                if (m_tdata[30:0] !== want) report_mismatch("code", m_tdata[30:0], want);
                if (m_tdata[31] !== 1'b0) report_mismatch("pad bit", {30'd0, m_tdata[31]}, 31'd0);
            end
        end
    end

    // receiver stall pattern: phases of free flow, of light stalling and of heavy stalling
    initial begin
        int ph;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            ph = int'(($time / 20000) % 3);
            if (ph == 0) m_tready <= 1'b1;
            else if (ph == 1) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 4) == 0);
        end
    end

    // s_tvalid stays high after a beat so that bursts run back to back
    task automatic send_beat(logic mode, logic [63:0] val);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= mode;
        code_q.insert(code_q.size(), otp_code(mode, val));
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain;
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (code_q.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        if (code_q.size() != 0) begin
            $display("TB_ERROR");
            $finish;
        end
        repeat (400) @(negedge aclk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_FIRST:  key_hi   = data;
            CFG_KEY_MIDDLE: key_mid  = data;
            CFG_KEY_LAST:   key_lo   = data[31:0];
            CFG_KEY_LENGTH: key_len  = data[4:0];
            CFG_DIGITS:     digits   = data[3:0];
            CFG_STEP:       step_sec = data[31:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_reset_defaults;
        send_beat(1'b1, 64'd0);
        send_beat(1'b0, 64'd59);
        send_beat(1'b1, '1);
        drain();
    endtask

    // rfc 4226 key with 6 and 8 digits, extremes of time and counter
    task automatic test_directed;
        write_reg(CFG_KEY_FIRST, 64'h3132333435363738);
        write_reg(CFG_KEY_MIDDLE, 64'h3930313233343536);
        write_reg(CFG_KEY_LAST, 64'h37383930);
        for (int i = 0; i < 10; i++) send_beat(1'b1, 64'(i));
        write_reg(CFG_DIGITS, 64'd8);
        send_beat(1'b0, 64'd59);
        send_beat(1'b0, 64'd1111111109);
        send_beat(1'b0, '1);
        send_beat(1'b1, 64'h8000000000000000);
        send_beat(1'b0, 64'h0000000000000000);
        drain();
        // zero step, zero digits, many digits, empty and oversize keys
        write_reg(CFG_STEP, 64'd0);
        write_reg(CFG_DIGITS, 64'd0);
        send_beat(1'b0, 64'd12345);
        write_reg(CFG_DIGITS, 64'd15);
        send_beat(1'b0, 64'd12345);
        write_reg(CFG_KEY_LENGTH, 64'd0);
        send_beat(1'b1, 64'd7);
        write_reg(CFG_KEY_LENGTH, 64'd31);
        send_beat(1'b1, 64'd7);
        write_reg(CFG_STEP, 64'hFFFFFFFF);
        write_reg(CFG_DIGITS, 64'd10);
        send_beat(1'b0, '1);
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 250 == 0) begin
                drain();
                write_reg(CFG_KEY_FIRST, rand64());
                write_reg(CFG_KEY_MIDDLE, rand64());
                write_reg(CFG_KEY_LAST, rand64());
                write_reg(CFG_KEY_LENGTH, 64'($urandom_range(0, 31)));
                write_reg(CFG_DIGITS, 64'($urandom_range(0, 15)));
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_STEP, 64'($urandom_range(0, 2)));
                    1: write_reg(CFG_STEP, 64'hFFFFFFFF);
                    default: write_reg(CFG_STEP, rand64());
                endcase
            end
            if (i == 1000) drain();
            send_beat(1'($urandom_range(0, 1)), rand64());
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_FIRST;
        cfg_wdata = '0;
        n_err = 0;
        burst_left = 0;
        key_hi = '0; key_mid = '0; key_lo = '0;
        key_len = 5'd20; digits = 4'd6; step_sec = 32'd30;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_directed();
        test_random(2000);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
